FILE: sv/skf_pkg.sv
// shared types, constants and saturation helpers for the scalar kalman filter
// used by skf_mul, skf_div and scalar_kalman_filter; no dependencies
package skf_pkg;

  localparam int FX_W      = 32;
  localparam int FRAC_W    = 16;
  localparam int VAR_W     = FX_W - 1;
  localparam int PROD_W    = 2 * FX_W;
  localparam int NUM_W     = FX_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(FX_W);
  localparam int CFG_IDX_W = 3;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic        [VAR_W-1:0]  var_t;
  typedef logic signed [FX_W+1:0]   wide_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam fx_t FX_ONE = fx_t'(1) << FRAC_W;

  // register map
  localparam cfg_idx_t REG_TRANSITION_GAIN   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_OBSERVATION_GAIN  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_PROCESS_NOISE_VAR = cfg_idx_t'(2);
  localparam cfg_idx_t REG_MEASURE_NOISE_VAR = cfg_idx_t'(3);
  localparam cfg_idx_t REG_PRIOR_MEAN        = cfg_idx_t'(4);
  localparam cfg_idx_t REG_PRIOR_VAR         = cfg_idx_t'(5);

  // reset values, q16.16 (variances unsigned q15.16)
  localparam fx_t  TRANSITION_GAIN_RST   = fx_t'(58982);
  localparam fx_t  OBSERVATION_GAIN_RST  = fx_t'(65536);
  localparam var_t PROCESS_NOISE_VAR_RST = var_t'(16384);
  localparam var_t MEASURE_NOISE_VAR_RST = var_t'(65536);
  localparam fx_t  PRIOR_MEAN_RST        = fx_t'(0);
  localparam var_t PRIOR_VAR_RST         = var_t'(65536);

  function automatic wide_t sx(input fx_t x);
    return wide_t'(x);
  endfunction

  function automatic wide_t zx(input var_t x);
    return wide_t'({1'b0, x});
  endfunction

  // clamp a sum of two fixed point values back to the data width
  function automatic fx_t fx_sat(input wide_t x);
    logic [2:0] hi;
    hi = x[FX_W+1:FX_W-1];
    if (hi == 3'b000 || hi == 3'b111) begin
      return x[FX_W-1:0];
    end else if (hi[2]) begin
      return FX_MIN;
    end else begin
      return FX_MAX;
    end
  endfunction

endpackage

FILE: sv/skf_mul.sv
// shared fixed point multiplier: registered product, then round half up and saturate
// depends on skf_pkg; both the product and the rounded result are registered on the way to res
module skf_mul (
  input  logic         clk,
  input  skf_pkg::fx_t op_a,
  input  skf_pkg::fx_t op_b,
  output skf_pkg::fx_t res
);
  import skf_pkg::*;

  localparam int SHR_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd;
  logic        [SHR_W-1:0]  shr;
  logic [SHR_W-FX_W:0]      hi;
  fx_t                      res_r;
  fx_t                      res_nxt;

  assign rnd = prod_r + $signed(PROD_W'(1) << (FRAC_W - 1));
  // floor shift is the upper bits of the rounded product
  assign shr = rnd[PROD_W-1:FRAC_W];
  assign hi  = shr[SHR_W-1:FX_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      res_nxt = shr[FX_W-1:0];
    end else if (hi[SHR_W-FX_W]) begin
      res_nxt = FX_MIN;
    end else begin
      res_nxt = FX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(PROD_W'(op_a)) * $signed(PROD_W'(op_b));
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: sv/skf_div.sv
// iterative restoring divider for the gain: one quotient bit a cycle,
// rounded half away from zero and saturated; depends on skf_pkg
module skf_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  skf_pkg::fx_t  num,
  input  skf_pkg::var_t den,
  output logic          done,
  output skf_pkg::fx_t  quo
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_t;

  dv_state_t              state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  var_t                   den_r, den_nxt;
  var_t                   rem_r, rem_nxt;
  logic [FX_W-1:0]        qs_r, qs_nxt;
  fx_t                    quo_r, quo_nxt;

  logic [FX_W-1:0]        mag;
  logic [NUM_W-1:0]       dividend;
  logic [FRAC_W-1:0]      dvd_hi;
  logic [VAR_W:0]         rem_sh;
  logic                   ge;
  logic                   lim;
  logic [FX_W-1:0]        mq;

  // magnitude scaled by one, plus half the divisor for rounding
  assign mag      = num[FX_W-1] ? (~num + FX_W'(1)) : num;
  assign dividend = {mag, FRAC_W'(0)} + NUM_W'(den >> 1);
  assign dvd_hi   = dividend[NUM_W-1:FX_W];

  assign rem_sh = {rem_r, qs_r[FX_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // quotient above 2^31 clamps before the sign is applied
  assign lim = ovf_r | (qs_r[FX_W-1] & (|qs_r[FX_W-2:0]));
  assign mq  = lim ? FX_MIN : qs_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    qs_nxt    = qs_r;
    quo_nxt   = quo_r;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_nxt   = num[FX_W-1];
          den_nxt   = den;
          // a high part not below the divisor means at least 2^32
          ovf_nxt   = VAR_W'(dvd_hi) >= den;
          rem_nxt   = VAR_W'(dvd_hi);
          qs_nxt    = dividend[FX_W-1:0];
          cnt_nxt   = DIV_CNT_W'(FX_W - 1);
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_nxt = ge ? VAR_W'(rem_sh - {1'b0, den_r}) : rem_sh[VAR_W-1:0];
        qs_nxt  = {qs_r[FX_W-2:0], ge};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = DV_FIN;
        end
      end
      DV_FIN: begin
        if (neg_r) begin
          quo_nxt = fx_t'(~mq + FX_W'(1));
        end else begin
          quo_nxt = mq[FX_W-1] ? FX_MAX : fx_t'(mq);
        end
        done_nxt  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: sv/scalar_kalman_filter.sv
// Scalar Kalman filter top level, signed Q16.16 with unsigned Q15.16 variances; depends on
// skf_pkg, skf_mul and skf_div. One observation goes in, one result (posterior mean,
// posterior variance, gain and a zero divisor flag) comes out. Items are handled one at a
// time: in_stall is low only while the sequencer is idle. For each item, ten multiplications
// run through the single multiplier, each in the MUL, RND and WB states, and the gain
// division runs in the bit-serial divider. The first item after reset skips the three
// prediction multiplies, and an item whose innovation variance is zero skips the divider.
// A finished result sits in an output register, so the next observation is taken while the
// previous result is still stalled. Configuration writes are always ready and must only be
// issued while the block is idle; the prior registers are used by the first item after reset
// only.
module scalar_kalman_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skf_pkg::fx_t      in_observation,
  output logic              out_valid,
  input  logic              out_stall,
  output skf_pkg::fx_t      out_post_mean,
  output skf_pkg::var_t     out_post_var,
  output skf_pkg::fx_t      out_gain_out,
  output logic              out_zero_divisor,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  skf_pkg::cfg_idx_t cfg_index,
  input  skf_pkg::fx_t      cfg_data
);
  import skf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RND  = 6'b000100,
    ST_WB   = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_AM  = 4'd0,  // a * last mean
    OP_AA  = 4'd1,  // a * a
    OP_AAP = 4'd2,  // a^2 * last var
    OP_CM  = 4'd3,  // c * predicted mean
    OP_CC  = 4'd4,  // c * c
    OP_CCP = 4'd5,  // c^2 * predicted var
    OP_PC  = 4'd6,  // predicted var * c
    OP_KE  = 4'd7,  // gain * innovation
    OP_KC  = 4'd8,  // gain * c
    OP_OMP = 4'd9   // (1 - k c) * predicted var
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   started_r, started_nxt;
  logic   out_valid_r, out_valid_nxt;
  fx_t    last_mean_r, last_mean_nxt;
  var_t   last_var_r, last_var_nxt;

  fx_t    tg_r, og_r, pm0_r;
  var_t   qn_r, rn_r, pv0_r;

  fx_t    y_r, y_nxt;
  fx_t    m_r, m_nxt;
  fx_t    p_r, p_nxt;
  fx_t    e_r, e_nxt;
  fx_t    t_r, t_nxt;
  fx_t    s_r, s_nxt;
  fx_t    k_r, k_nxt;
  logic   zero_r, zero_nxt;
  fx_t    pm_r, pm_nxt;
  var_t   pv_r, pv_nxt;

  fx_t    out_pm_r, out_pm_nxt;
  var_t   out_pv_r, out_pv_nxt;
  fx_t    out_k_r, out_k_nxt;
  logic   out_zero_r, out_zero_nxt;

  fx_t    mul_a, mul_b, mul_res;
  logic   div_start, div_done;
  fx_t    div_quo;
  logic   out_load;

  skf_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_res),
    .den   (s_r[VAR_W-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (op_r)
      OP_AM: begin
        mul_a = tg_r;
        mul_b = last_mean_r;
      end
      OP_AA: begin
        mul_a = tg_r;
        mul_b = tg_r;
      end
      OP_AAP: begin
        mul_a = t_r;
        mul_b = $signed({1'b0, last_var_r});
      end
      OP_CM: begin
        mul_a = og_r;
        mul_b = m_r;
      end
      OP_CC: begin
        mul_a = og_r;
        mul_b = og_r;
      end
      OP_CCP: begin
        mul_a = t_r;
        mul_b = p_r;
      end
      OP_PC: begin
        mul_a = p_r;
        mul_b = og_r;
      end
      OP_KE: begin
        mul_a = k_r;
        mul_b = e_r;
      end
      OP_KC: begin
        mul_a = k_r;
        mul_b = og_r;
      end
      default: begin
        mul_a = t_r;
        mul_b = p_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    started_nxt   = started_r;
    last_mean_nxt = last_mean_r;
    last_var_nxt  = last_var_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    e_nxt         = e_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    k_nxt         = k_r;
    zero_nxt      = zero_r;
    pm_nxt        = pm_r;
    pv_nxt        = pv_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          y_nxt     = in_observation;
          state_nxt = ST_MUL;
          if (started_r) begin
            op_nxt = OP_AM;
          end else begin
            // first item predicts straight from the prior
            m_nxt  = pm0_r;
            p_nxt  = $signed({1'b0, pv0_r});
            op_nxt = OP_CM;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_RND;
      end
      ST_RND: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        state_nxt = ST_MUL;
        case (op_r)
          OP_AM: begin
            m_nxt  = mul_res;
            op_nxt = OP_AA;
          end
          OP_AA: begin
            t_nxt  = mul_res;
            op_nxt = OP_AAP;
          end
          OP_AAP: begin
            p_nxt  = fx_sat(sx(mul_res) + zx(qn_r));
            op_nxt = OP_CM;
          end
          OP_CM: begin
            e_nxt  = fx_sat(sx(y_r) - sx(mul_res));
            op_nxt = OP_CC;
          end
          OP_CC: begin
            t_nxt  = mul_res;
            op_nxt = OP_CCP;
          end
          OP_CCP: begin
            s_nxt  = fx_sat(sx(mul_res) + zx(rn_r));
            op_nxt = OP_PC;
          end
          OP_PC: begin
            op_nxt = OP_KE;
            if (s_r == '0) begin
              k_nxt    = '0;
              zero_nxt = 1'b1;
            end else begin
              zero_nxt  = 1'b0;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
          OP_KE: begin
            pm_nxt = fx_sat(sx(m_r) + sx(mul_res));
            op_nxt = OP_KC;
          end
          OP_KC: begin
            t_nxt  = fx_sat(sx(FX_ONE) - sx(mul_res));
            op_nxt = OP_OMP;
          end
          OP_OMP: begin
            // rounding can push the variance below zero
            pv_nxt        = mul_res[FX_W-1] ? '0 : mul_res[VAR_W-1:0];
            last_mean_nxt = pm_r;
            last_var_nxt  = mul_res[FX_W-1] ? '0 : mul_res[VAR_W-1:0];
            started_nxt   = 1'b1;
            state_nxt     = ST_OUT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          k_nxt     = div_quo;
          op_nxt    = OP_KE;
          state_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register holds a result until its transfer
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);
  assign out_pm_nxt    = out_load ? pm_r : out_pm_r;
  assign out_pv_nxt    = out_load ? pv_r : out_pv_r;
  assign out_k_nxt     = out_load ? k_r : out_k_r;
  assign out_zero_nxt  = out_load ? zero_r : out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AM;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      last_mean_r <= '0;
      last_var_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      last_mean_r <= last_mean_nxt;
      last_var_r  <= last_var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tg_r  <= TRANSITION_GAIN_RST;
      og_r  <= OBSERVATION_GAIN_RST;
      qn_r  <= PROCESS_NOISE_VAR_RST;
      rn_r  <= MEASURE_NOISE_VAR_RST;
      pm0_r <= PRIOR_MEAN_RST;
      pv0_r <= PRIOR_VAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRANSITION_GAIN:   tg_r  <= cfg_data;
        REG_OBSERVATION_GAIN:  og_r  <= cfg_data;
        REG_PROCESS_NOISE_VAR: qn_r  <= cfg_data[VAR_W-1:0];
        REG_MEASURE_NOISE_VAR: rn_r  <= cfg_data[VAR_W-1:0];
        REG_PRIOR_MEAN:        pm0_r <= cfg_data;
        REG_PRIOR_VAR:         pv0_r <= cfg_data[VAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    p_r        <= p_nxt;
    e_r        <= e_nxt;
    t_r        <= t_nxt;
    s_r        <= s_nxt;
    k_r        <= k_nxt;
    zero_r     <= zero_nxt;
    pm_r       <= pm_nxt;
    pv_r       <= pv_nxt;
    out_pm_r   <= out_pm_nxt;
    out_pv_r   <= out_pv_nxt;
    out_k_r    <= out_k_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_post_mean    = out_pm_r;
  assign out_post_var     = out_pv_r;
  assign out_gain_out     = out_k_r;
  assign out_zero_divisor = out_zero_r;

endmodule

FILE: tb/tb.sv
// self-checking testbench for scalar_kalman_filter: directed table, then random filter settings
// with random observations, checked against the table or a q16.16 kalman step predictor
// depends on skf_pkg and the scalar_kalman_filter rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  typedef struct packed {
    fx_t  post_mean;
    var_t post_var;
    fx_t  gain;
    logic zero_div;
  } estimate_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_OBS, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t  idx;
    fx_t       value;
    estimate_t want;
  } stim_row_t;

  // indexes past the register map, writes there must be dropped
  localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(6);
  localparam cfg_idx_t REG_SPARE_HI = cfg_idx_t'(7);

  localparam longint FX_TOP    = (longint'(1) <<< (FX_W - 1)) - 1;
  localparam longint FX_BOTTOM = -FX_TOP - 1;
  localparam longint VAR_TOP   = (longint'(1) <<< VAR_W) - 1;
  localparam longint UNITY     = longint'(1) <<< FRAC_W;
  localparam longint HALF_LSB  = UNITY / 2;

  localparam int RANDOM_ITEMS = 485;
  localparam int MAX_WAIT     = 19;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_PAUSE   = 4;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRESSURE_SET = 2;

  localparam fx_t       VAR_FULL    = fx_t'(32'h7FFF_FFFF);
  localparam estimate_t NO_ESTIMATE = '0;
  // zero divisor on the first item: posterior is the prior, prior_var is 0
  localparam estimate_t FIRST_ZERO_DIV = '{FX_MIN, var_t'(0), fx_t'(0), 1'b1};
  // a = 0, c = 0, r = 0: prediction is (0, q) and passes straight through
  localparam estimate_t HELD_ZERO_DIV  = '{fx_t'(0), var_t'(VAR_FULL), fx_t'(0), 1'b1};

  localparam stim_row_t DIRECTED [0:35] = '{
    '{ROW_CFG,   REG_PRIOR_MEAN,        FX_MIN,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_PRIOR_VAR,         fx_t'(0),               NO_ESTIMATE},
    '{ROW_CFG,   REG_MEASURE_NOISE_VAR, fx_t'(0),               NO_ESTIMATE},
    '{ROW_KNOWN, '0,                    FX_MAX,                 FIRST_ZERO_DIV},
    '{ROW_OBS,   '0,                    FX_MIN,                 NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(0),               NO_ESTIMATE},
    '{ROW_CFG,   REG_MEASURE_NOISE_VAR, VAR_FULL,               NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'h0001_0000),   NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(-1),              NO_ESTIMATE},
    '{ROW_CFG,   REG_TRANSITION_GAIN,   FX_MAX,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_OBSERVATION_GAIN,  FX_MIN,                 NO_ESTIMATE},
    '{ROW_OBS,   '0,                    FX_MAX,                 NO_ESTIMATE},
    '{ROW_OBS,   '0,                    FX_MIN,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_TRANSITION_GAIN,   FX_MIN,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_OBSERVATION_GAIN,  FX_MAX,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_PROCESS_NOISE_VAR, VAR_FULL,               NO_ESTIMATE},
    // top bit set, masked away by the 31 bit register
    '{ROW_CFG,   REG_MEASURE_NOISE_VAR, fx_t'(32'h8000_0000),   NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'h5555_5555),   NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'hAAAA_AAAA),   NO_ESTIMATE},
    '{ROW_CFG,   REG_TRANSITION_GAIN,   fx_t'(0),               NO_ESTIMATE},
    '{ROW_CFG,   REG_OBSERVATION_GAIN,  fx_t'(0),               NO_ESTIMATE},
    '{ROW_KNOWN, '0,                    fx_t'(32'h1234_5678),   HELD_ZERO_DIV},
    '{ROW_CFG,   REG_SPARE_LO,          FX_MAX,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_SPARE_HI,          fx_t'(32'h0000_FFFF),   NO_ESTIMATE},
    // prior rewritten after the first item, must not take effect
    '{ROW_CFG,   REG_PRIOR_MEAN,        FX_MAX,                 NO_ESTIMATE},
    '{ROW_CFG,   REG_PRIOR_VAR,         VAR_FULL,               NO_ESTIMATE},
    '{ROW_KNOWN, '0,                    FX_MIN,                 HELD_ZERO_DIV},
    // c*c rounds to zero, so the innovation variance vanishes again
    '{ROW_CFG,   REG_OBSERVATION_GAIN,  fx_t'(1),               NO_ESTIMATE},
    '{ROW_CFG,   REG_TRANSITION_GAIN,   TRANSITION_GAIN_RST,    NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'h00FF_00FF),   NO_ESTIMATE},
    '{ROW_CFG,   REG_OBSERVATION_GAIN,  OBSERVATION_GAIN_RST,   NO_ESTIMATE},
    '{ROW_CFG,   REG_PROCESS_NOISE_VAR, fx_t'(PROCESS_NOISE_VAR_RST), NO_ESTIMATE},
    '{ROW_CFG,   REG_MEASURE_NOISE_VAR, fx_t'(MEASURE_NOISE_VAR_RST), NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(0),               NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'h0003_0000),   NO_ESTIMATE},
    '{ROW_OBS,   '0,                    fx_t'(32'hFFFD_0000),   NO_ESTIMATE}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fx_t      in_observation = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fx_t      out_post_mean;
  var_t     out_post_var;
  fx_t      out_gain_out;
  logic     out_zero_divisor;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  fx_t      cfg_data = '0;

  // filter settings and running estimate as the block should hold them
  longint trans_a    = longint'(TRANSITION_GAIN_RST);
  longint obs_c      = longint'(OBSERVATION_GAIN_RST);
  longint proc_q     = longint'(PROCESS_NOISE_VAR_RST);
  longint meas_r     = longint'(MEASURE_NOISE_VAR_RST);
  longint start_mean = longint'(PRIOR_MEAN_RST);
  longint start_var  = longint'(PRIOR_VAR_RST);
  longint est_mean   = 0;
  longint est_var    = 0;
  bit     est_started = 1'b0;

  estimate_t pending_estimates [$];

  bit tx_gaps_on    = 1'b1;
  bit rx_gaps_on    = 1'b1;
  bit hold_off_req  = 1'b0;
  int items_sent     = 0;
  int results_seen   = 0;
  int zero_div_seen  = 0;
  int reg_writes     = 0;
  int mismatches     = 0;

  scalar_kalman_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_observation   (in_observation),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_post_mean    (out_post_mean),
    .out_post_var     (out_post_var),
    .out_gain_out     (out_gain_out),
    .out_zero_divisor (out_zero_divisor),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat_fx(input longint x);
    if (x > FX_TOP) return FX_TOP;
    if (x < FX_BOTTOM) return FX_BOTTOM;
    return x;
  endfunction

  // product rounded half up, then clamped to the data width
  function automatic longint q_mul(input longint a, input longint b);
    return sat_fx((a * b + HALF_LSB) >>> FRAC_W);
  endfunction

  // quotient rounded half away from zero
  function automatic longint q_div(input longint num, input longint den);
    longint mag;
    longint quo;
    mag = (num < 0 ? -num : num) * UNITY;
    quo = (mag + den / 2) / den;
    if (quo > FX_TOP + 1) quo = FX_TOP + 1;
    return sat_fx(num < 0 ? -quo : quo);
  endfunction

  function automatic estimate_t kalman_step(input fx_t obs);
    longint m, p, e, s, k, pm, pv;
    estimate_t r;
    if (!est_started) begin
      m = start_mean;
      p = start_var;
    end else begin
      m = q_mul(trans_a, est_mean);
      p = sat_fx(q_mul(q_mul(trans_a, trans_a), est_var) + proc_q);
    end
    e = sat_fx(longint'(obs) - q_mul(obs_c, m));
    s = sat_fx(q_mul(q_mul(obs_c, obs_c), p) + meas_r);
    r.zero_div = (s <= 0);
    k = r.zero_div ? 0 : q_div(q_mul(p, obs_c), s);
    pm = sat_fx(m + q_mul(k, e));
    pv = q_mul(sat_fx(UNITY - q_mul(k, obs_c)), p);
    if (pv < 0) pv = 0;
    if (pv > VAR_TOP) pv = VAR_TOP;
    est_mean = pm;
    est_var = pv;
    est_started = 1'b1;
    r.post_mean = fx_t'(pm);
    r.post_var = var_t'(pv);
    r.gain = fx_t'(k);
    return r;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input fx_t data);
    case (idx)
      REG_TRANSITION_GAIN:   trans_a = longint'(data);
      REG_OBSERVATION_GAIN:  obs_c = longint'(data);
      REG_PROCESS_NOISE_VAR: proc_q = longint'(data[VAR_W-1:0]);
      REG_MEASURE_NOISE_VAR: meas_r = longint'(data[VAR_W-1:0]);
      REG_PRIOR_MEAN:        start_mean = longint'(data);
      REG_PRIOR_VAR:         start_var = longint'(data[VAR_W-1:0]);
      default: ;
    endcase
  endfunction

  // variance register value, with a random bit above the register width
  function automatic fx_t pick_variance();
    var_t v;
    logic top;
    top = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = var_t'($urandom);
      default: v = var_t'($urandom_range(0, 262144));
    endcase
    return {top, v};
  endfunction

  // stop offering and wait until every accepted observation has its result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input fx_t data);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_obs(input fx_t y, input logic known, input estimate_t want);
    int gap;
    estimate_t got;
    gap = tx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_observation <= y;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // the predictor always runs so its state follows the block
    got = kalman_step(y);
    pending_estimates = {pending_estimates, (known ? want : got)};
    items_sent++;
  endtask

  initial begin : stimulus
    fx_t y;
    fx_t level;
    int  spread;
    int  n_items;
    int  random_items;
    int  directed_items;
    int  phase_no;
    logic coin;
    random_items = 0;
    phase_no = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      tx_gaps_on = 1'($urandom_range(0, 1));
      case (DIRECTED[i].kind)
        ROW_CFG: write_reg(DIRECTED[i].idx, DIRECTED[i].value);
        ROW_OBS: send_obs(DIRECTED[i].value, 1'b0, NO_ESTIMATE);
        default: send_obs(DIRECTED[i].value, 1'b1, DIRECTED[i].want);
      endcase
    end
    directed_items = items_sent;

    while (random_items < RANDOM_ITEMS) begin
      coin = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: y = coin ? FX_MAX : FX_MIN;
        1: y = '0;
        default: y = fx_t'($urandom_range(0, 157286)) - fx_t'(78643);
      endcase
      write_reg(REG_TRANSITION_GAIN, y);
      coin = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: y = coin ? FX_MAX : FX_MIN;
        1: y = fx_t'($urandom_range(0, 511)) - fx_t'(256);
        default: begin
          y = fx_t'($urandom_range(6554, 262144));
          if (coin) y = -y;
        end
      endcase
      write_reg(REG_OBSERVATION_GAIN, y);
      write_reg(REG_PROCESS_NOISE_VAR, pick_variance());
      write_reg(REG_MEASURE_NOISE_VAR, pick_variance());
      if ($urandom_range(0, 3) == 0) write_reg(REG_PRIOR_MEAN, fx_t'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(REG_PRIOR_VAR, pick_variance());
      if ($urandom_range(0, 7) == 0) begin
        coin = 1'($urandom_range(0, 1));
        write_reg(coin ? REG_SPARE_LO : REG_SPARE_HI, fx_t'($urandom));
      end
      phase_no++;

      // observations scatter around a level, with some wild samples mixed in
      level = fx_t'($urandom_range(0, 13107200)) - fx_t'(6553600);
      spread = $urandom_range(1, 1 << 20);
      n_items = $urandom_range(15, 45);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      if (phase_no == PRESSURE_SET) begin
        n_items = 30;
        tx_gaps_on = 1'b0;
      end
      for (int j = 0; j < n_items; j++) begin
        // keep offering while the result side holds off
        if (phase_no == PRESSURE_SET && j == 3) hold_off_req = 1'b1;
        case ($urandom_range(0, 19))
          0: y = FX_MAX;
          1: y = FX_MIN;
          2, 3: y = fx_t'($urandom);
          default: y = level + fx_t'($urandom_range(0, 2 * spread)) - fx_t'(spread);
        endcase
        send_obs(y, 1'b0, NO_ESTIMATE);
        random_items++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d observations sent (%0d directed, %0d random) over %0d random filter settings",
             items_sent, directed_items, random_items, phase_no);
    $display("%0d register writes, %0d estimates checked, %0d with zero innovation variance",
             reg_writes, results_seen, zero_div_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_side
    int gap;
    estimate_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen % 32 == 0) rx_gaps_on = ($urandom_range(0, 3) != 0);
      gap = rx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_off_req) begin
        gap = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pending_estimates.size() == 0) begin
        $error("result transfer with no observation outstanding");
        mismatches++;
      end else begin
        want = pending_estimates.pop_front();
        if (want.zero_div) zero_div_seen++;
        if (out_post_mean !== want.post_mean) begin
          $error("post_mean: expected %0d, actual %0d", want.post_mean, out_post_mean);
          mismatches++;
        end
        if (out_post_var !== want.post_var) begin
          $error("post_var: expected %0d, actual %0d", want.post_var, out_post_var);
          mismatches++;
        end
        if (out_gain_out !== want.gain) begin
          $error("gain_out: expected %0d, actual %0d", want.gain, out_gain_out);
          mismatches++;
        end
        if (out_zero_divisor !== want.zero_div) begin
          $error("zero_divisor: expected %0d, actual %0d", want.zero_div, out_zero_divisor);
          mismatches++;
        end
      end
    end
  end

  // allow several times the slowest legal run before giving up
  initial begin : watchdog
    #5_000_000;
    $error("timed out with %0d estimates outstanding", pending_estimates.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
sv/skf_pkg.sv
sv/skf_mul.sv
sv/skf_div.sv
sv/scalar_kalman_filter.sv
tb/tb.sv
